/* design/ghash_pkg.sv */
// ----------------------------------------------------------------------------
// GHASH package
// Widths, constants, shared types and the GF(2^128) digit step.
// ----------------------------------------------------------------------------
package ghash_pkg;

   localparam int HalfWidth  = 64;
   localparam int BlockWidth = 2 * HalfWidth;
   localparam int DigitWidth = 8;
   localparam int DigitCount = BlockWidth / DigitWidth;
   localparam int CountWidth = $clog2(DigitCount);
   localparam int CsrAddrWidth = 4;
   localparam int CsrDataWidth = 64;

   localparam logic [BlockWidth-1:0] ReduceConst = {8'hE1, {(BlockWidth-8){1'b0}}};

   typedef enum logic {
      CSR_HASH_KEY_HIGH = 1'b0,
      CSR_HASH_KEY_LOW  = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic start;
   } mul_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mul_stat_type;

   typedef struct packed {
      logic [BlockWidth-1:0] p;
      logic [BlockWidth-1:0] v;
   } mul_state_type;

   // Absorbs one digit of the multiplier operand, most significant bit first.
   function automatic mul_state_type ghash_digit_step(mul_state_type st,
                                                      logic [DigitWidth-1:0] digit);
      mul_state_type res;
      logic          carry;
      res = st;
      for (int i = 0; i < DigitWidth; i++) begin
         if (digit[DigitWidth-1-i]) begin
            res.p = res.p ^ res.v;
         end
         carry = res.v[0];
         res.v = res.v >> 1;
         if (carry) begin
            res.v = res.v ^ ReduceConst;
         end
      end
      return res;
   endfunction

endpackage

/* design/ghash_if.sv */
// ----------------------------------------------------------------------------
// GHASH channel interfaces
// Valid/ready channels for the data blocks and the hash results.
// ----------------------------------------------------------------------------
interface ghash_req_if import ghash_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [HalfWidth-1:0] block_high;
   logic [HalfWidth-1:0] block_low;
   logic                 restart;

   modport source (output valid, output block_high, output block_low, output restart,
                   input ready);
   modport sink   (input valid, input block_high, input block_low, input restart,
                   output ready);
endinterface

interface ghash_rsp_if import ghash_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [HalfWidth-1:0] hash_high;
   logic [HalfWidth-1:0] hash_low;

   modport source (output valid, output hash_high, output hash_low, input ready);
   modport sink   (input valid, input hash_high, input hash_low, output ready);
endinterface

/* design/ghash_mul.sv */
// ----------------------------------------------------------------------------
// GHASH digit-serial multiplier
// Multiplies two GF(2^128) elements in GCM bit order, one 8-bit digit of
// the first operand per cycle.
// ----------------------------------------------------------------------------
module ghash_mul import ghash_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  mul_ctrl_type          ctrl,
   input  logic [BlockWidth-1:0] x,
   input  logic [BlockWidth-1:0] y,
   output mul_stat_type          stat,
   output logic [BlockWidth-1:0] product
);

   logic [BlockWidth-1:0] x_ff;
   mul_state_type         acc_ff;
   mul_state_type         acc_in;
   logic [CountWidth-1:0] count_ff;
   logic                  running_ff;
   logic                  done_ff;

   always_comb begin
      acc_in = ghash_digit_step(acc_ff, x_ff[BlockWidth-1 -: DigitWidth]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
         count_ff   <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctrl.start) begin
            x_ff       <= x;
            acc_ff.p   <= '0;
            acc_ff.v   <= y;
            count_ff   <= '0;
            running_ff <= 1'b1;
         end else if (running_ff) begin
            x_ff     <= x_ff << DigitWidth;
            acc_ff   <= acc_in;
            count_ff <= count_ff + 1'b1;
            if (count_ff == CountWidth'(DigitCount - 1)) begin
               running_ff <= 1'b0;
               done_ff    <= 1'b1;
            end
         end
      end
   end

   assign stat.busy = running_ff;
   assign stat.done = done_ff;
   assign product   = acc_ff.p;

endmodule

/* design/ghash_accumulator.sv */
// ----------------------------------------------------------------------------
// GHASH accumulator
// Absorbs 128-bit blocks into the GHASH accumulator and returns the hash
// after every block.
// ----------------------------------------------------------------------------
//  Port group   Direction  Contents
//  req_chan     in         block_high, block_low, restart (valid/ready)
//  rsp_chan     out        hash_high, hash_low (valid/ready)
//  csr_*        in/out     APB-style access to hash_key_high (0x0), hash_key_low (0x8)
//
// Each word passes through the 8-bit digit-serial multiplier and then the
// output register before its result is valid; the block takes no new word
// while the previous one is still being multiplied or held.
// A new word is accepted only once the previous product has been taken into
// the output register. The output register holds a result while the sink
// stalls; a finished product waits in the accumulator until it is free.
// Reset clears the accumulator, the hash key and all control state.
// ----------------------------------------------------------------------------
module ghash_accumulator import ghash_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   ghash_req_if.sink               req_chan,
   ghash_rsp_if.source             rsp_chan,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [CsrDataWidth-1:0] csr_pwdata,
   output logic [CsrDataWidth-1:0] csr_prdata,
   output logic                    csr_pready
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BUSY,
      ST_HOLD
   } state_type;

   state_type             state_ff;
   logic [BlockWidth-1:0] key_ff;
   logic [BlockWidth-1:0] acc_ff;
   logic [BlockWidth-1:0] rsp_hash_ff;
   logic                  rsp_valid_ff;
   logic [BlockWidth-1:0] mul_x;
   logic [BlockWidth-1:0] product;
   mul_ctrl_type          mul_ctrl;
   mul_stat_type          mul_stat;
   logic                  req_take;
   logic                  rsp_take;
   logic                  rsp_free;
   logic                  csr_write;
   csr_index_type         csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_index_type'(csr_paddr[CsrAddrWidth-1]);

   always_comb begin
      unique case (csr_index)
         CSR_HASH_KEY_HIGH: csr_prdata = key_ff[BlockWidth-1 -: HalfWidth];
         CSR_HASH_KEY_LOW:  csr_prdata = key_ff[HalfWidth-1:0];
         default:           csr_prdata = '0;
      endcase
   end

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_take       = req_chan.valid && req_chan.ready;
   assign rsp_take       = rsp_valid_ff && rsp_chan.ready;
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;

   assign mul_ctrl.start = req_take;
   assign mul_x = (req_chan.restart ? '0 : acc_ff)
                  ^ {req_chan.block_high, req_chan.block_low};

   ghash_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (mul_ctrl),
      .x       (mul_x),
      .y       (key_ff),
      .stat    (mul_stat),
      .product (product)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_HASH_KEY_HIGH: key_ff[BlockWidth-1 -: HalfWidth] <= csr_pwdata;
            CSR_HASH_KEY_LOW:  key_ff[HalfWidth-1:0]             <= csr_pwdata;
            default:           key_ff                            <= key_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_take) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  state_ff <= ST_BUSY;
               end
            end
            ST_BUSY: begin
               if (mul_stat.done) begin
                  acc_ff <= product;
                  if (rsp_free) begin
                     rsp_hash_ff  <= product;
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= ST_IDLE;
                  end else begin
                     state_ff <= ST_HOLD;
                  end
               end
            end
            ST_HOLD: begin
               if (rsp_free) begin
                  rsp_hash_ff  <= acc_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.hash_high = rsp_hash_ff[BlockWidth-1 -: HalfWidth];
   assign rsp_chan.hash_low  = rsp_hash_ff[HalfWidth-1:0];

endmodule

/* design/ghash_checker.sv */
// ----------------------------------------------------------------------------
// GHASH port checker
// Concurrent checks on the channel behaviour seen at the top-level ports.
// ----------------------------------------------------------------------------
module ghash_port_checker import ghash_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [HalfWidth-1:0] hash_high,
   input logic [HalfWidth-1:0] hash_low
);

   logic req_take;

   assign req_take = req_valid && req_ready;

   a_rsp_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

   a_rsp_word_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(hash_high) && $stable(hash_low))
      else $error("rsp word changed while stalled");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_take |=> !req_ready)
      else $error("req ready straight after a word was taken");

   a_busy_mid_multiply: assert property (@(posedge clock) disable iff (reset)
      req_take |-> ##8 !req_ready)
      else $error("req ready before the multiplication finished");

   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not idle after reset");

endmodule

bind ghash_accumulator ghash_port_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .hash_high (rsp_chan.hash_high),
   .hash_low  (rsp_chan.hash_low)
);

/* tb/sv/ghash_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// GHASH result checker
// Follows key register traffic and accepted data words, keeps its own copy
// of the running hash in GF(2^128), and compares every returned hash word
// with the oldest expected one. Key read-backs are checked as well.
// ----------------------------------------------------------------------------
module ghash_checker import ghash_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   ghash_req_if                    req_chan,
   ghash_rsp_if                    rsp_chan,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [CsrDataWidth-1:0] csr_pwdata,
   input  logic [CsrDataWidth-1:0] csr_prdata,
   input  logic                    csr_pready,
   output int unsigned             mismatches,
   output int unsigned             outstanding,
   output int unsigned             hashes_checked
);

   localparam int PrintLimit = 30;

   typedef struct packed {
      logic [HalfWidth-1:0] hash_high;
      logic [HalfWidth-1:0] hash_low;
   } hash_word_type;

   logic [BlockWidth-1:0] hash_key;
   logic [BlockWidth-1:0] running_hash;
   hash_word_type         expected_hashes[$];

   // Bit 127 of the vector is the coefficient of x^0, as GCM orders the field.
   function automatic logic [BlockWidth-1:0] gf128_product(input logic [BlockWidth-1:0] a,
                                                           input logic [BlockWidth-1:0] b);
      logic [BlockWidth-1:0] prod;
      logic [BlockWidth-1:0] shifted;
      prod    = '0;
      shifted = b;
      for (int k = BlockWidth - 1; k >= 0; k--) begin
         if (a[k]) begin
            prod = prod ^ shifted;
         end
         if (shifted[0]) begin
            shifted = (shifted >> 1) ^ ReduceConst;
         end else begin
            shifted = shifted >> 1;
         end
      end
      return prod;
   endfunction

   task automatic report_mismatch(input string what, input logic [HalfWidth-1:0] got,
                                  input logic [HalfWidth-1:0] want);
      if (mismatches < PrintLimit) begin
         $display("%0t: %s: got %h, expected %h", $time, what, got, want);
      end
      mismatches++;
   endtask

   always @(posedge clock) begin
      hash_word_type got;
      hash_word_type want;
      csr_index_type index;
      if (reset) begin
         hash_key     = '0;
         running_hash = '0;
         expected_hashes.delete();
         mismatches     = 0;
         hashes_checked = 0;
      end else begin
         index = csr_index_type'(csr_paddr >> 3);
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               if (index == CSR_HASH_KEY_HIGH) begin
                  hash_key[BlockWidth-1:HalfWidth] = csr_pwdata;
               end else begin
                  hash_key[HalfWidth-1:0] = csr_pwdata;
               end
            end else if (index == CSR_HASH_KEY_HIGH) begin
               if (csr_prdata != hash_key[BlockWidth-1:HalfWidth]) begin
                  report_mismatch("hash_key_high read-back", csr_prdata,
                                  hash_key[BlockWidth-1:HalfWidth]);
               end
            end else if (csr_prdata != hash_key[HalfWidth-1:0]) begin
               report_mismatch("hash_key_low read-back", csr_prdata, hash_key[HalfWidth-1:0]);
            end
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.hash_high = rsp_chan.hash_high;
            got.hash_low  = rsp_chan.hash_low;
            if (expected_hashes.size() == 0) begin
               report_mismatch("hash word with none pending", got.hash_high, '0);
            end else begin
               want = expected_hashes.pop_front();
               if (got.hash_high != want.hash_high) begin
                  report_mismatch("hash_high", got.hash_high, want.hash_high);
               end
               if (got.hash_low != want.hash_low) begin
                  report_mismatch("hash_low", got.hash_low, want.hash_low);
               end
               hashes_checked++;
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            if (req_chan.restart) begin
               running_hash = '0;
            end
            running_hash = gf128_product(running_hash ^ {req_chan.block_high, req_chan.block_low},
                                         hash_key);
            expected_hashes.push_back(running_hash);
         end
      end
      outstanding <= expected_hashes.size();
   end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// GHASH accumulator testbench
// Writes hash keys over the register port and feeds data words, first a
// directed set of extremes, then random messages under several keys, with
// random gaps on both channels. The checker module judges every hash word.
// ----------------------------------------------------------------------------
module tb;
   import ghash_pkg::*;

   localparam int StallLimit    = 4000;
   localparam int DrainCycles   = 40;
   localparam int RandomPhases  = 6;
   localparam int WordsPerPhase = 200;
   localparam int SteadyPhase   = 3;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    steady;
   logic                    sink_ready = 1'b0;
   logic                    csr_psel;
   logic                    csr_penable;
   logic                    csr_pwrite;
   logic [CsrAddrWidth-1:0] csr_paddr;
   logic [CsrDataWidth-1:0] csr_pwdata;
   logic [CsrDataWidth-1:0] csr_prdata;
   logic                    csr_pready;
   int unsigned             mismatches;
   int unsigned             outstanding;
   int unsigned             hashes_checked;
   int unsigned             words_sent;
   int unsigned             restarts_sent;
   int unsigned             key_writes;
   int unsigned             message_left;
   int unsigned             stall_cycles;

   ghash_req_if req_chan ();
   ghash_rsp_if rsp_chan ();

   assign rsp_chan.ready = sink_ready;

   ghash_accumulator i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   ghash_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .mismatches     (mismatches),
      .outstanding    (outstanding),
      .hashes_checked (hashes_checked)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      sink_ready <= steady || ($urandom_range(99) >= 21);
   end

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
          csr_psel) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   function automatic logic [HalfWidth-1:0] random_half();
      case ($urandom_range(15))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic send_word(input logic [HalfWidth-1:0] high_half,
                            input logic [HalfWidth-1:0] low_half, input logic restart);
      while (!steady && $urandom_range(99) < 21) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.block_high <= high_half;
      req_chan.block_low  <= low_half;
      req_chan.restart    <= restart;
      do @(posedge clock); while (!req_chan.ready);
      words_sent++;
      if (restart) begin
         restarts_sent++;
      end
   endtask

   // The select stays high between back-to-back transfers; set_key ends a batch.
   task automatic csr_access(input csr_index_type index, input logic write,
                             input logic [CsrDataWidth-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= CsrAddrWidth'(index) << 3;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (write) begin
         key_writes++;
      end
   endtask

   task automatic set_key(input logic [BlockWidth-1:0] key);
      csr_access(CSR_HASH_KEY_HIGH, 1'b1, key[BlockWidth-1:HalfWidth]);
      csr_access(CSR_HASH_KEY_LOW, 1'b1, key[HalfWidth-1:0]);
      csr_access(CSR_HASH_KEY_HIGH, 1'b0, '0);
      csr_access(CSR_HASH_KEY_LOW, 1'b0, '0);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic run_messages(input int unsigned count);
      logic restart;
      for (int n = 0; n < count; n++) begin
         restart = 1'b0;
         if (message_left == 0) begin
            restart      = 1'b1;
            message_left = $urandom_range(12, 1);
         end else if ($urandom_range(19) == 0) begin
            restart = 1'b1;
         end
         message_left--;
         send_word(random_half(), random_half(), restart);
      end
   endtask

   initial begin
      logic [BlockWidth-1:0] phase_keys [RandomPhases];
      req_chan.valid      <= 1'b0;
      req_chan.block_high <= '0;
      req_chan.block_low  <= '0;
      req_chan.restart    <= 1'b0;
      csr_psel            <= 1'b0;
      csr_penable         <= 1'b0;
      csr_pwrite          <= 1'b0;
      csr_paddr           <= '0;
      csr_pwdata          <= '0;
      steady              <= 1'b0;
      reset               <= 1'b1;
      words_sent    = 0;
      restarts_sent = 0;
      key_writes    = 0;
      message_left  = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // With the key still zero after reset, every hash must be zero.
      send_word('1, '1, 1'b0);
      send_word(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 1'b1);
      send_word('0, '0, 1'b0);
      wait_drained();

      // The key 1 (top bit only) is the unit of the field.
      set_key({64'h8000_0000_0000_0000, 64'h0});
      send_word(64'h8000_0000_0000_0000, '0, 1'b1);
      send_word('0, 64'h1, 1'b0);
      send_word('1, '1, 1'b0);
      send_word(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 1'b1);
      wait_drained();

      set_key('1);
      send_word('1, '1, 1'b1);
      send_word('0, '0, 1'b0);
      send_word('0, 64'h1, 1'b0);
      send_word(64'h8000_0000_0000_0000, '0, 1'b1);
      wait_drained();

      // A key change in the middle of a message keeps the accumulator.
      set_key({64'hffff_ffff_ffff_ffff, 64'h1});
      send_word(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 1'b0);
      send_word('1, '0, 1'b0);
      send_word('0, '1, 1'b1);
      wait_drained();

      phase_keys[0] = {$urandom, $urandom, $urandom, $urandom};
      phase_keys[1] = {64'h0, $urandom, $urandom};
      phase_keys[2] = '1;
      phase_keys[3] = {$urandom, $urandom, $urandom, $urandom};
      phase_keys[4] = {64'h0, 64'h1};
      phase_keys[5] = {$urandom, $urandom, 64'h0};
      for (int p = 0; p < RandomPhases; p++) begin
         set_key(phase_keys[p]);
         steady <= (p == SteadyPhase);
         run_messages(WordsPerPhase);
         wait_drained();
      end
      steady <= 1'b0;

      repeat (DrainCycles) @(posedge clock);
      $display("Sent %0d data words (%0d with restart) under %0d key register writes.",
               words_sent, restarts_sent, key_writes);
      $display("Checked %0d hash words; one phase ran with neither side idling.",
               hashes_checked);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
